// File: design/olist_pkg.sv
`default_nettype none

package olist_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int ACT_W    = 3;
  localparam int FOUND_W  = 4;
  localparam int FILL_W   = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_POP    = 3'd4,
    ACT_TAKE   = 3'd5
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APPEND,
    S_READ,
    S_READ_WAIT,
    S_REMOVE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP,
    S_POP_WAIT,
    S_TAKE,
    S_TAKE_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ADDR_POS,
    ADDR_IDX,
    ADDR_IDX_NEXT,
    ADDR_TAIL,
    ADDR_HEAD,
    ADDR_CNT
  } addr_sel_t;

  typedef enum logic {
    WD_IN,
    WD_RDATA
  } wd_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_in;
    addr_sel_t addr_sel;
    logic      mem_rd;
    logic      mem_wr;
    wd_sel_t   wd_sel;
    logic      idx_load_pos;
    logic      idx_clear;
    logic      idx_inc;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      set_ok;
    logic      take_rdata;
    logic      take_found;
    logic      out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_lt_cnt;
    logic cnt_zero;
    logic app_ok;
    logic idx_lt_cnt;
    logic idx_next_lt_cnt;
    logic match;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: design/ordered_list_engine.sv
// One item at a time: a new input beat is taken only in the idle state, after
// the previous result has been loaded into the output register. Remove and
// take shift the entries down through the single-port store, a read state and
// a write state per entry; search walks it with a read and a compare state per
// entry. Synchronous active-high reset empties the list and drops any pending
// output beat; the entry store itself is not cleared.
`default_nettype none

module ordered_list_engine
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic [POS_W-1:0]         position_in,
  input  wire logic signed [DATA_W-1:0] data_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          ok,
  output logic signed [DATA_W-1:0]      data_out,
  output logic [FOUND_W-1:0]            found_at,
  output logic [FILL_W-1:0]             fill
);

  // The controller sequences each action over the entry store; the datapath
  // holds the store, the count, the walk index and the output register.
  // Because the result sits in its own register, a new input beat is taken
  // while the previous result still waits for out_ready.
  cmd_t cmd;
  sts_t sts;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .sts      (sts),
    .cmd      (cmd)
  );

  olist_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .position_in (position_in),
    .data_in     (data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .data_out    (data_out),
    .found_at    (found_at),
    .fill        (fill)
  );

endmodule

`default_nettype wire

// File: design/olist_dp.sv
`default_nettype none

module olist_dp
  import olist_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cmd_t                     cmd,
  output sts_t                          sts,
  input  wire logic [POS_W-1:0]         position_in,
  input  wire logic signed [DATA_W-1:0] data_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          ok,
  output logic signed [DATA_W-1:0]      data_out,
  output logic [FOUND_W-1:0]            found_at,
  output logic [FILL_W-1:0]             fill
);

  logic [DATA_W-1:0]  mem [DEPTH];
  logic [DATA_W-1:0]  rdata;
  logic [POS_W-1:0]   pos_q;
  logic [DATA_W-1:0]  data_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic               res_ok;
  logic [DATA_W-1:0]  res_dout;
  logic [FOUND_W-1:0] res_found;
  logic [CNT_W-1:0]   idx_plus;
  logic [CNT_W-1:0]   count_minus;
  logic [IDX_W-1:0]   addr;
  logic [DATA_W-1:0]  wdata;
  logic [CNT_W:0]     idx_next_ext;

  assign idx_plus     = idx + CNT_W'(1);
  assign count_minus  = count - CNT_W'(1);
  assign idx_next_ext = {1'b0, idx} + (CNT_W + 1)'(1);

  always_comb begin
    case (cmd.addr_sel)
      ADDR_POS:      addr = pos_q[IDX_W-1:0];
      ADDR_IDX:      addr = idx[IDX_W-1:0];
      ADDR_IDX_NEXT: addr = idx_plus[IDX_W-1:0];
      ADDR_TAIL:     addr = count_minus[IDX_W-1:0];
      ADDR_CNT:      addr = count[IDX_W-1:0];
      default:       addr = '0;
    endcase
    wdata = (cmd.wd_sel == WD_RDATA) ? rdata : data_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  always_comb begin
    sts.pos_lt_cnt      = POS_W'(count) > pos_q;
    sts.cnt_zero        = count == '0;
    sts.app_ok          = (count != CNT_W'(DEPTH)) &&
                          ((count == '0) || (pos_q >= POS_W'(count)));
    sts.idx_lt_cnt      = idx < count;
    sts.idx_next_lt_cnt = idx_next_ext < {1'b0, count};
    sts.match           = rdata == data_q;
    sts.out_free        = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_q  <= position_in;
      data_q <= data_in;
    end
    if (cmd.load_in) begin
      res_ok    <= 1'b0;
      res_dout  <= '0;
      res_found <= '0;
    end else begin
      if (cmd.set_ok) begin
        res_ok <= 1'b1;
      end
      if (cmd.take_rdata) begin
        res_dout <= rdata;
      end
      if (cmd.take_found) begin
        res_found <= FOUND_W'(idx);
      end
    end
    if (cmd.idx_load_pos) begin
      idx <= CNT_W'(pos_q);
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx_plus;
    end
    if (cmd.out_load) begin
      ok       <= res_ok;
      data_out <= res_dout;
      found_at <= res_found;
      fill     <= FILL_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count_minus;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/olist_ctrl.sv
`default_nettype none

module olist_ctrl
  import olist_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] action,
  input  wire sts_t             sts,
  output cmd_t                  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.addr_sel = ADDR_IDX;
    cmd.wd_sel   = WD_IN;
    unique case (state)
      S_IDLE: begin
        // No beat is taken while reset is held.
        in_ready = !rst;
        if (in_valid) begin
          cmd.load_in   = 1'b1;
          cmd.idx_clear = 1'b1;
          unique case (action)
            ACT_APPEND: state_next = S_APPEND;
            ACT_READ:   state_next = S_READ;
            ACT_REMOVE: state_next = S_REMOVE;
            ACT_SEARCH: state_next = S_SRCH_RD;
            ACT_POP:    state_next = S_POP;
            ACT_TAKE:   state_next = S_TAKE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_APPEND: begin
        if (sts.app_ok) begin
          cmd.addr_sel = ADDR_CNT;
          cmd.mem_wr   = 1'b1;
          cmd.cnt_inc  = 1'b1;
          cmd.set_ok   = 1'b1;
        end
        state_next = S_DONE;
      end
      S_READ: begin
        if (sts.pos_lt_cnt) begin
          cmd.addr_sel = ADDR_POS;
          cmd.mem_rd   = 1'b1;
          state_next   = S_READ_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ_WAIT: begin
        cmd.take_rdata = 1'b1;
        cmd.set_ok     = 1'b1;
        state_next     = S_DONE;
      end
      S_REMOVE: begin
        if (sts.pos_lt_cnt) begin
          cmd.idx_load_pos = 1'b1;
          cmd.set_ok       = 1'b1;
          state_next       = S_SHIFT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_RD: begin
        if (sts.idx_next_lt_cnt) begin
          cmd.addr_sel = ADDR_IDX_NEXT;
          cmd.mem_rd   = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        cmd.addr_sel = ADDR_IDX;
        cmd.wd_sel   = WD_RDATA;
        cmd.mem_wr   = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_POP: begin
        if (!sts.cnt_zero) begin
          cmd.addr_sel = ADDR_TAIL;
          cmd.mem_rd   = 1'b1;
          state_next   = S_POP_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POP_WAIT: begin
        cmd.take_rdata = 1'b1;
        cmd.set_ok     = 1'b1;
        cmd.cnt_dec    = 1'b1;
        state_next     = S_DONE;
      end
      S_TAKE: begin
        if (!sts.cnt_zero) begin
          cmd.addr_sel = ADDR_HEAD;
          cmd.mem_rd   = 1'b1;
          state_next   = S_TAKE_WAIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_TAKE_WAIT: begin
        cmd.take_rdata = 1'b1;
        cmd.set_ok     = 1'b1;
        cmd.idx_clear  = 1'b1;
        state_next     = S_SHIFT_RD;
      end
      S_SRCH_RD: begin
        if (sts.idx_lt_cnt) begin
          cmd.addr_sel = ADDR_IDX;
          cmd.mem_rd   = 1'b1;
          state_next   = S_SRCH_CMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRCH_CMP: begin
        if (sts.match) begin
          cmd.set_ok     = 1'b1;
          cmd.take_found = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
